>>> rtl/coin_change_min_coins_assert.svh
// Assertion macros for the coin change RTL, included by the sequencer ccmc_ctrl.
`ifndef COIN_CHANGE_MIN_COINS_ASSERT_SVH
`define COIN_CHANGE_MIN_COINS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CCMC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CCMC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CCMC_ASSERT_IMP(label, ante, cons)
`define CCMC_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> rtl/ccmc_pkg.sv
// Types, constants and helpers for the coin change block.
package ccmc_pkg;

	localparam int MAX_TARGET = 1023;
	localparam int NUM_COINS  = 6;
	localparam int REG_COINS  = 6;
	localparam int COUNT_MAX  = 1023;

	localparam int ACT_MAX = (NUM_COINS < REG_COINS) ? NUM_COINS : REG_COINS;

	localparam int TGT_W    = 12;
	localparam int COIN_W   = 10;
	localparam int TOT_W    = 10;
	localparam int STAT_W   = 2;
	localparam int CCNT_W   = 3;
	localparam int CIDX_W   = $clog2(REG_COINS);
	localparam int CFG_W    = COIN_W;
	localparam int AMT_W    = $clog2(MAX_TARGET + 1);
	localparam int CNT_W    = AMT_W;
	localparam int TBL_DEPTH = MAX_TARGET + 1;
	localparam int CMP_W    = (AMT_W > COIN_W) ? AMT_W : COIN_W;

	// register indexes
	localparam logic [CCNT_W-1:0] REG_COIN_COUNT = CCNT_W'(0);
	localparam logic [CCNT_W-1:0] REG_COIN_LAST  = CCNT_W'(REG_COINS);

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_IMPOSSIBLE = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_COINS   = 2'd3;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [TOT_W-1:0]  coin_total;
	} res_t;

	typedef struct packed {
		logic                                clear;
		logic [CCNT_W-1:0]                   active;
		logic [REG_COINS-1:0][COIN_W-1:0]    value;
	} coin_cfg_t;

	function automatic res_t make_result(entry_t e);
		res_t r;
		r.status     = ST_IMPOSSIBLE;
		r.coin_total = '0;
		if (e.found) begin
			r.status = ST_OK;
			if (32'(e.count) > COUNT_MAX) begin
				r.coin_total = TOT_W'(COUNT_MAX);
			end else begin
				r.coin_total = TOT_W'(e.count);
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/ccmc_cfg.sv
// Configuration registers: coin count and coin values.
module ccmc_cfg import ccmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CCNT_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data,
	output coin_cfg_t         cfg
);

	logic [CCNT_W-1:0]               coin_count_q;
	logic [REG_COINS-1:0][COIN_W-1:0] coin_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_count_q <= '0;
			for (int k = 0; k < REG_COINS; k++) begin
				coin_value_q[k] <= COIN_W'(1);
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_COIN_COUNT) begin
				coin_count_q <= cfg_data[CCNT_W-1:0];
			end else if (cfg_idx <= REG_COIN_LAST) begin
				coin_value_q[CIDX_W'(cfg_idx - CCNT_W'(1))] <= cfg_data[COIN_W-1:0];
			end
		end
	end

	always_comb begin
		cfg.value  = coin_value_q;
		cfg.active = (coin_count_q > CCNT_W'(ACT_MAX)) ? CCNT_W'(ACT_MAX) : coin_count_q;
		// any known register written drops the solved range
		cfg.clear  = cfg_we && (cfg_idx <= REG_COIN_LAST);
	end

endmodule

>>> rtl/ccmc_table.sv
// Answer table: one write port, one read port with registered read data.
module ccmc_table import ccmc_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [AMT_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [AMT_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/ccmc_ctrl.sv
// Sequencer: table lookup, table extension and result formation.
module ccmc_ctrl import ccmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  coin_cfg_t        cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [TGT_W-1:0] in_target,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	output logic [AMT_W-1:0] tbl_raddr,
	input  entry_t           tbl_rdata,
	output logic             tbl_we,
	output logic [AMT_W-1:0] tbl_waddr,
	output entry_t           tbl_wdata
);

	`include "coin_change_min_coins_assert.svh"

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FILL  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_LOOK  = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]        state_q;
	logic [AMT_W-1:0]  frontier_q;
	logic [AMT_W-1:0]  target_q;
	logic [AMT_W-1:0]  amt_q;
	logic [CIDX_W-1:0] coin_idx_q;
	entry_t            best_q;
	res_t              res_q;

	// compare stage
	logic              vld_s1;
	logic              use_s1;
	logic              zero_s1;
	logic              first_s1;
	logic              last_s1;
	logic              fwd_s1;
	logic [AMT_W-1:0]  amt_s1;
	entry_t            fwd_data_s1;

	logic              issuing;
	logic [COIN_W-1:0] coin_c;
	logic              coin_use;
	logic [AMT_W-1:0]  prev_addr;
	logic              last_coin;
	logic              fwd_now;
	logic              done_cmp;
	logic              base_found;
	logic              take;
	entry_t            cand;
	entry_t            new_best;

	// issue side: one coin per cycle
	always_comb begin
		issuing   = (state_q == S_FILL);
		coin_c    = cfg.value[coin_idx_q];
		coin_use  = (coin_c != '0) && (CMP_W'(coin_c) <= CMP_W'(amt_q));
		prev_addr = AMT_W'(CMP_W'(amt_q) - CMP_W'(coin_c));
		last_coin = (CCNT_W'(coin_idx_q) == CCNT_W'(cfg.active - CCNT_W'(1)));
		tbl_raddr = issuing ? prev_addr : in_target[AMT_W-1:0];
	end

	// compare side: fold one candidate into the running minimum
	always_comb begin
		if (zero_s1) begin
			cand.found = 1'b1;
			cand.count = '0;
		end else if (fwd_s1) begin
			cand = fwd_data_s1;
		end else begin
			cand = tbl_rdata;
		end
		base_found     = !first_s1 && best_q.found;
		take           = use_s1 && cand.found && (!base_found || cand.count < best_q.count);
		new_best.found = take || base_found;
		new_best.count = take ? cand.count : best_q.count;

		tbl_we          = vld_s1 && last_s1;
		tbl_waddr       = amt_s1;
		tbl_wdata.found = new_best.found;
		tbl_wdata.count = new_best.found ? CNT_W'(new_best.count + CNT_W'(1)) : '0;

		// the entry written at this edge is the one being read: take it directly
		fwd_now  = tbl_we && issuing && (prev_addr == amt_s1);
		done_cmp = tbl_we && (amt_s1 == target_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issuing;
		end
	end

	always_ff @(posedge clk) begin
		use_s1      <= coin_use;
		zero_s1     <= (prev_addr == '0);
		first_s1    <= (coin_idx_q == '0);
		last_s1     <= last_coin;
		amt_s1      <= amt_q;
		fwd_s1      <= fwd_now;
		fwd_data_s1 <= tbl_wdata;
		if (vld_s1) begin
			best_q <= new_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			frontier_q <= '0;
			target_q   <= '0;
			amt_q      <= '0;
			coin_idx_q <= '0;
			res_q      <= '0;
		end else begin
			if (cfg.clear) begin
				frontier_q <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						target_q   <= in_target[AMT_W-1:0];
						amt_q      <= AMT_W'(frontier_q + AMT_W'(1));
						coin_idx_q <= '0;
						if (cfg.active == '0) begin
							res_q.status     <= ST_NO_COINS;
							res_q.coin_total <= '0;
							state_q          <= S_RESP;
						end else if (in_target > TGT_W'(MAX_TARGET)) begin
							res_q.status     <= ST_RANGE;
							res_q.coin_total <= '0;
							state_q          <= S_RESP;
						end else if (in_target[AMT_W-1:0] <= frontier_q) begin
							state_q <= S_LOOK;
						end else begin
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					if (last_coin) begin
						coin_idx_q <= '0;
						if (amt_q == target_q) begin
							state_q <= S_DRAIN;
						end else begin
							amt_q <= AMT_W'(amt_q + AMT_W'(1));
						end
					end else begin
						coin_idx_q <= CIDX_W'(coin_idx_q + CIDX_W'(1));
					end
				end
				S_DRAIN: begin
					if (done_cmp) begin
						res_q      <= make_result(tbl_wdata);
						frontier_q <= target_q;
						state_q    <= S_RESP;
					end
				end
				S_LOOK: begin
					if (target_q == '0) begin
						res_q.status     <= ST_OK;
						res_q.coin_total <= '0;
					end else begin
						res_q <= make_result(tbl_rdata);
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	`CCMC_ASSERT_IMP(a_s1_in_fill, vld_s1, (state_q == S_FILL) || (state_q == S_DRAIN))
	`CCMC_ASSERT_IMP(a_amt_bounded, state_q == S_FILL, (amt_q <= target_q) && (amt_q > frontier_q))
	`CCMC_ASSERT_IMP(a_entry_zero_kept, tbl_we, tbl_waddr != '0)
	`CCMC_ASSERT_NXT(a_drain_after_last,
		(state_q == S_FILL) && last_coin && (amt_q == target_q), state_q == S_DRAIN)

endmodule

>>> rtl/coin_change_min_coins.sv
// Top level of the fewest-coins change maker with a memo table.
//
//  channel | dir | fields (low bit up)                        | accepted when
//  s_*     | in  | tdata: target_amount[11:0], pad            | s_tvalid & s_tready
//  m_*     | out | tdata: coin_total[9:0], status[11:10], pad | m_tvalid & m_tready
//  cfg_*   | in  | idx 0 coin_count, 1..6 coin_value_0..5     | cfg_we
//
// A target at or below the solved range is answered by a single table lookup.
// A larger target first extends the table from the frontier up to the target: the
// table read port serves one coin per cycle, with the written entry forwarded.
// Reset clears the solved range; the table needs no clearing pass.
// The next item is taken while the previous result sits in the output register.
module coin_change_min_coins import ccmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // target_amount[11:0], zeros
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // coin_total[9:0], status[11:10], zeros
	input  logic              cfg_we,
	input  logic [CCNT_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_data
);

	coin_cfg_t        cfg;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic [AMT_W-1:0] tbl_raddr;
	entry_t           tbl_rdata;
	logic             tbl_we;
	logic [AMT_W-1:0] tbl_waddr;
	entry_t           tbl_wdata;
	logic             m_tvalid_q;
	res_t             out_q;

	ccmc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	ccmc_table u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ccmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_target (s_tdata[TGT_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.tbl_raddr (tbl_raddr),
		.tbl_rdata (tbl_rdata),
		.tbl_we    (tbl_we),
		.tbl_waddr (tbl_waddr),
		.tbl_wdata (tbl_wdata)
	);

	// output register: load when empty or being drained
	assign res_ready = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - TOT_W - STAT_W){1'b0}}, out_q.status, out_q.coin_total};

endmodule

>>> test/tb_coin_change_min_coins.sv
// Self-checking testbench for the fewest-coins change maker.
`timescale 1ns / 100ps

module tb_coin_change_min_coins;
	import ccmc_pkg::*;

	localparam int                WATCHDOG_LIMIT = 40000;
	localparam int                HOLD_CYCLES    = 300;
	localparam int                SETTLE_CYCLES  = 8;
	localparam logic [CCNT_W-1:0] REG_UNUSED     = 3'd7;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata  = '0;   // target_amount[11:0], zeros
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;         // coin_total[9:0], status[11:10], zeros
	logic              cfg_we   = 1'b0;
	logic [CCNT_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	coin_change_min_coins DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// change maker state as the block should hold it
	logic [CCNT_W-1:0] coin_cnt_m;
	logic [COIN_W-1:0] coin_val_m [REG_COINS];
	int                frontier_m;
	int                best_m [TBL_DEPTH];
	bit                reach_m [TBL_DEPTH];

	res_t expected_change [$];

	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_req        = 0;
	int hold_left       = 0;
	int quiet_cycles    = 0;
	int mismatches      = 0;
	int items_sent      = 0;
	int answers_checked = 0;
	int reg_writes      = 0;

	function automatic res_t change_for(input int target);
		int   ncoins;
		int   a;
		int   j;
		int   prev;
		int   best;
		bit   found;
		res_t r;
		r.coin_total = '0;
		ncoins = coin_cnt_m;
		if (ncoins > ACT_MAX) ncoins = ACT_MAX;
		if (ncoins == 0) begin
			r.status = ST_NO_COINS;
			return r;
		end
		if (target > MAX_TARGET) begin
			r.status = ST_RANGE;
			return r;
		end
		if (target > frontier_m) begin
			for (a = frontier_m + 1; a <= target; a++) begin
				found = 1'b0;
				best  = 0;
				for (j = 0; j < ncoins; j++) begin
					// skip absent coins, coins too large and unreachable remainders
					if (coin_val_m[j] == 0 || int'(coin_val_m[j]) > a) continue;
					prev = a - int'(coin_val_m[j]);
					if (!reach_m[prev]) continue;
					if (!found || best_m[prev] < best) begin
						best  = best_m[prev];
						found = 1'b1;
					end
				end
				reach_m[a] = found;
				best_m[a]  = found ? best + 1 : 0;
			end
			frontier_m = target;
		end
		if (!reach_m[target]) begin
			r.status = ST_IMPOSSIBLE;
			return r;
		end
		r.status     = ST_OK;
		r.coin_total = (best_m[target] > COUNT_MAX) ? TOT_W'(COUNT_MAX) : TOT_W'(best_m[target]);
		return r;
	endfunction

	function automatic void apply_reg(input logic [CCNT_W-1:0] idx, input logic [CFG_W-1:0] data);
		if (idx == REG_COIN_COUNT) begin
			coin_cnt_m = data[CCNT_W-1:0];
		end else if (idx <= REG_COIN_LAST) begin
			coin_val_m[int'(idx) - 1] = data;
		end else begin
			return;
		end
		frontier_m = 0;
	endfunction

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected total %0d status %0d, got total %0d status %0d",
				$realtime, what, want.coin_total, want.status, got.coin_total, got.status);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.coin_total = m_tdata[TOT_W-1:0];
			got.status     = m_tdata[TOT_W+STAT_W-1:TOT_W];
			answers_checked++;
			if (expected_change.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
			end else begin
				want = expected_change.pop_front();
				if (got.coin_total != want.coin_total)
					note_mismatch("coin_total mismatch", want, got);
				else if (got.status != want.status)
					note_mismatch("status mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_target(input logic [TGT_W-1:0] target);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 16'(target);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_change.push_back(change_for(int'(target)));
		items_sent++;
	endtask

	// drop valid and wait until every answer is back and the block is at rest
	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_change.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CCNT_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coins(input logic [CFG_W-1:0] cnt,
			input logic [CFG_W-1:0] v0, input logic [CFG_W-1:0] v1,
			input logic [CFG_W-1:0] v2, input logic [CFG_W-1:0] v3,
			input logic [CFG_W-1:0] v4, input logic [CFG_W-1:0] v5);
		drain();
		write_reg(REG_COIN_COUNT + 3'd1, v0);
		write_reg(REG_COIN_COUNT + 3'd2, v1);
		write_reg(REG_COIN_COUNT + 3'd3, v2);
		write_reg(REG_COIN_COUNT + 3'd4, v3);
		write_reg(REG_COIN_COUNT + 3'd5, v4);
		write_reg(REG_COIN_LAST, v5);
		write_reg(REG_COIN_COUNT, cnt);
	endtask

	function automatic logic [CFG_W-1:0] rand_coin();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 15) return CFG_W'($urandom_range(1023, 1));
		return CFG_W'($urandom_range(30, 1));
	endfunction

	// mostly small targets so the table stays cheap, some full range, some out of range
	function automatic logic [TGT_W-1:0] rand_target();
		int r;
		r = $urandom_range(99);
		if (r < 10) return TGT_W'($urandom_range(4095, MAX_TARGET + 1));
		if (r < 20) return TGT_W'($urandom_range(MAX_TARGET, 0));
		return TGT_W'($urandom_range(200, 0));
	endfunction

	task automatic test_unconfigured;
		send_target(TGT_W'(0));
		send_target(TGT_W'(4095));
	endtask

	task automatic test_common_coins;
		load_coins(10'd4, 10'd1, 10'd5, 10'd10, 10'd25, 10'd1, 10'd1);
		send_target(TGT_W'(0));
		send_target(TGT_W'(30));
		send_target(TGT_W'(63));
		send_target(TGT_W'(MAX_TARGET));
		send_target(TGT_W'(MAX_TARGET + 1));
		send_target(TGT_W'(4095));
		send_target(TGT_W'(30));
	endtask

	task automatic test_unreachable_and_zero_coin;
		load_coins(10'd2, 10'd4, 10'd6, 10'd1, 10'd1, 10'd1, 10'd1);
		send_target(TGT_W'(5));
		send_target(TGT_W'(7));
		send_target(TGT_W'(12));
		// a zero coin must be skipped
		load_coins(10'd3, 10'd0, 10'd3, 10'd7, 10'd1, 10'd1, 10'd1);
		send_target(TGT_W'(10));
		send_target(TGT_W'(1));
	endtask

	task automatic test_register_edges;
		// count field 7 saturates to six coins; only the sixth coin makes 4 in two
		load_coins(10'h3FF, 10'd1023, 10'd9, 10'd9, 10'd9, 10'd9, 10'd2);
		send_target(TGT_W'(4));
		send_target(TGT_W'(MAX_TARGET));
		drain();
		write_reg(REG_UNUSED, '0);
		send_target(TGT_W'(MAX_TARGET));
		// a lone unit coin gives the largest count
		load_coins(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
		send_target(TGT_W'(MAX_TARGET));
		send_target(TGT_W'(512));
	endtask

	task automatic test_random_phases;
		int idle_tab  [4] = '{0, 49, 0, 6};
		int stall_tab [4] = '{0, 0, 49, 6};
		int p;
		int round;
		int k;
		for (p = 0; p < 4; p++) begin
			for (round = 0; round < 2; round++) begin
				load_coins(($urandom_range(15) == 0) ? '0 : CFG_W'($urandom_range(7, 1)),
					rand_coin(), rand_coin(), rand_coin(),
					rand_coin(), rand_coin(), rand_coin());
				sender_idle_pct = idle_tab[p];
				recv_stall_pct  = stall_tab[p];
				for (k = 0; k < 8; k++) send_target(rand_target());
				drain();
				sender_idle_pct = 0;
				recv_stall_pct  = 0;
			end
		end
	endtask

	task automatic test_backpressure;
		int k;
		load_coins(10'd3, 10'd3, 10'd5, 10'd11, 10'd1, 10'd1, 10'd1);
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_req        = HOLD_CYCLES;
		// keep offering while the output is held, so the input backs up
		for (k = 0; k < 20; k++) send_target(rand_target());
	endtask

	initial begin
		coin_cnt_m = '0;
		for (int k = 0; k < REG_COINS; k++) coin_val_m[k] = CFG_W'(1);
		frontier_m = 0;
		reach_m[0] = 1'b1;
		best_m[0]  = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unconfigured();
		test_common_coins();
		test_unreachable_and_zero_coin();
		test_register_edges();
		test_random_phases();
		test_backpressure();

		drain();
		repeat (20) @(posedge clk);
		if (expected_change.size() != 0) begin
			mismatches += expected_change.size();
			$display("%0d expected answers never arrived", expected_change.size());
		end
		$display("Sent %0d targets and checked %0d answers across %0d register writes,",
			items_sent, answers_checked, reg_writes);
		$display("with idle, stall and %0d-cycle hold-off phases; %0d mismatches.",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
